### src/srdr_pkg.sv
// Shared constants and helpers for the SHiP-style RRIP replacement unit.
// No dependencies.
package srdr_pkg;

	localparam int unsigned NUM_SETS_DEF = 2048;
	localparam int unsigned NUM_WAYS_DEF = 16;

	localparam int unsigned SIG_W     = 6;
	localparam int unsigned SIG_N     = 64;
	localparam int unsigned LINE_W    = 58;
	localparam int unsigned STRIDE_W  = 64;
	localparam int unsigned STREAK_W  = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [1:0] RRPV_MAX      = 2'd3;
	localparam logic [1:0] CNT_MAX       = 2'd3;
	localparam logic [1:0] OUTCOME_RESET = 2'd1;

	localparam logic [STREAK_W-1:0] STREAK_MAX = 4'd15;
	localparam logic [STREAK_W-1:0] THR_RESET  = 4'd4;
	localparam logic [15:0]         MASK_RESET = 16'd4095;

	localparam logic [CFG_IDX_W-1:0] REG_STREAK_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_MASK = 2'd1;

	// v mod n by restoring subtraction, n >= 1
	function automatic logic [15:0] mod_sub(input logic [15:0] v, input logic [16:0] n);
		logic [15:0] r;
		logic [32:0] t;
		r = v;
		for (int k = 15; k >= 0; k--) begin
			t = 33'(n) << k;
			if (t <= 33'(r))
				r = r - 16'(t);
		end
		return r;
	endfunction

	function automatic logic [1:0] sat_inc(input logic [1:0] v);
		return (v == CNT_MAX) ? v : v + 2'd1;
	endfunction

	function automatic logic [1:0] sat_dec(input logic [1:0] v);
		return (v == 2'd0) ? v : v - 2'd1;
	endfunction

endpackage

### src/ship_rrip_stream_deadblock_replacement_unit.sv
// Top level of the SHiP-style RRIP replacement unit with dead-block and stride tracking.
// Depends on srdr_pkg and srdr_ram.
//
//   channel | signals                                              | dir
//   --------+------------------------------------------------------+----
//   in      | in_valid/in_ready, req_type set_index way_index       | in
//           | phys_addr pc was_hit                                 |
//   out     | out_valid/out_ready, victim_way streaming_detected    | out
//   cfg     | cfg_we cfg_index cfg_data                            | in
//
// Victim request: the set row is read (ST_RD), one way a cycle goes through the shared scan
// unit (ST_SCAN), then the aged row is written back and the result is registered (ST_VWR).
// Update request: row read (ST_RD), stride and outcome reads (ST_U1), row write-back (ST_U2);
// a decay pass (ST_DEC, one set row a cycle) runs first when the decay mask selects it.
// After reset a clearing pass over max(NUM_SETS, 64) entries runs before in_ready rises.
// One beat is in flight at a time; in_ready stays low while a result waits on out_ready, so
// the next input beat is taken in the cycle after the result beat at the earliest.
module ship_rrip_stream_deadblock_replacement_unit #(
	parameter int unsigned NUM_SETS = srdr_pkg::NUM_SETS_DEF,
	parameter int unsigned NUM_WAYS = srdr_pkg::NUM_WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [10:0] set_index,
	input  logic [3:0]  way_index,
	input  logic [63:0] phys_addr,
	input  logic [63:0] pc,
	input  logic        was_hit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  victim_way,
	output logic        streaming_detected,
	input  logic        cfg_we,
	input  logic [srdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srdr_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int unsigned SAW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned WW    = $clog2(NUM_WAYS);
	localparam int unsigned CLR_N = (NUM_SETS > 64) ? NUM_SETS : 64;
	localparam int unsigned CW    = $clog2(CLR_N);
	localparam int unsigned DW    = $clog2(NUM_SETS + 1);
	localparam int unsigned RW    = 2 * NUM_WAYS;
	localparam int unsigned SRW   = srdr_pkg::SIG_W * NUM_WAYS;
	localparam int unsigned SW    = srdr_pkg::SIG_W;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_DEC, ST_RD, ST_SCAN, ST_VWR, ST_U1, ST_U2
	} state_t;

	state_t state_q;

	logic [CW-1:0]  clr_q;
	logic [DW-1:0]  dec_q;
	logic [WW-1:0]  scan_q;
	logic [1:0]     top_q;
	logic [WW-1:0]  first_q, dz_idx_q;
	logic           dz_v_q;

	logic [3:0]     thr_q;
	logic [15:0]    mask_q;
	logic [15:0]    upd_cnt_q;

	logic           req_q, hit_q;
	logic [SAW-1:0] set_q;
	logic [WW-1:0]  way_q;
	logic [srdr_pkg::LINE_W-1:0] line_q;
	logic [SW-1:0]  sig_q, old_sig_q;
	logic           stream_q;
	logic [1:0]     o_new_q;

	logic           out_valid_q, stream_out_q;
	logic [3:0]     victim_q;

	// memory ports
	logic           rr_we, dc_we, sg_we, pl_we, ps_we, sk_we, oc_we;
	logic [SAW-1:0] row_waddr, dc_waddr, dc_raddr;
	logic [RW-1:0]  rr_wdata, rr_rd, dc_wdata, dc_rd;
	logic [SRW-1:0] sg_wdata, sg_rd;
	logic [srdr_pkg::LINE_W-1:0]   pl_wdata, pl_rd;
	logic [srdr_pkg::STRIDE_W-1:0] ps_wdata, ps_rd;
	logic [3:0]     sk_wdata, sk_rd;
	logic [SW-1:0]  oc_waddr, oc_raddr;
	logic [1:0]     oc_wdata, oc_rd;

	srdr_ram #(.W(RW), .D(NUM_SETS), .AW(SAW)) u_rrpv (
		.clk, .we(rr_we), .waddr(row_waddr), .wdata(rr_wdata), .raddr(set_q), .rdata(rr_rd));
	srdr_ram #(.W(RW), .D(NUM_SETS), .AW(SAW)) u_dead (
		.clk, .we(dc_we), .waddr(dc_waddr), .wdata(dc_wdata), .raddr(dc_raddr), .rdata(dc_rd));
	srdr_ram #(.W(SRW), .D(NUM_SETS), .AW(SAW)) u_bsig (
		.clk, .we(sg_we), .waddr(row_waddr), .wdata(sg_wdata), .raddr(set_q), .rdata(sg_rd));
	srdr_ram #(.W(srdr_pkg::LINE_W), .D(NUM_SETS), .AW(SAW)) u_pline (
		.clk, .we(pl_we), .waddr(row_waddr), .wdata(pl_wdata), .raddr(set_q), .rdata(pl_rd));
	srdr_ram #(.W(srdr_pkg::STRIDE_W), .D(NUM_SETS), .AW(SAW)) u_pstride (
		.clk, .we(ps_we), .waddr(row_waddr), .wdata(ps_wdata), .raddr(set_q), .rdata(ps_rd));
	srdr_ram #(.W(4), .D(NUM_SETS), .AW(SAW)) u_streak (
		.clk, .we(sk_we), .waddr(row_waddr), .wdata(sk_wdata), .raddr(set_q), .rdata(sk_rd));
	srdr_ram #(.W(2), .D(srdr_pkg::SIG_N), .AW(SW)) u_outcome (
		.clk, .we(oc_we), .waddr(oc_waddr), .wdata(oc_wdata), .raddr(oc_raddr), .rdata(oc_rd));

	assign in_ready           = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid          = out_valid_q;
	assign victim_way         = victim_q;
	assign streaming_detected = stream_out_q;

	// stride unit and per-way views of the current set
	logic [63:0] stride;
	logic        same_stride, streaming;
	logic [1:0]  scan_rr, scan_dc, way_rr, way_dc, o_old_dec, o_eff;
	logic [SW-1:0] way_sig;
	logic [RW-1:0] aged_row;
	logic [WW-1:0] vidx;
	logic [3:0]    streak_nx;

	assign stride      = {6'd0, line_q} - {6'd0, pl_rd};
	assign same_stride = (stride != 64'd0) && (stride == ps_rd);
	assign streaming   = same_stride && (sk_rd >= thr_q);
	assign streak_nx   = !same_stride ? 4'd0 :
		(sk_rd == srdr_pkg::STREAK_MAX) ? sk_rd : sk_rd + 4'd1;
	assign scan_rr     = rr_rd[2*scan_q +: 2];
	assign scan_dc     = dc_rd[2*scan_q +: 2];
	assign way_rr      = rr_rd[2*way_q +: 2];
	assign way_dc      = dc_rd[2*way_q +: 2];
	assign way_sig     = sg_rd[SW*way_q +: SW];
	assign o_old_dec   = srdr_pkg::sat_dec(oc_rd);
	assign o_eff       = (old_sig_q == sig_q) ? o_old_dec : o_new_q;
	assign vidx        = dz_v_q ? dz_idx_q : first_q;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++)
			aged_row[2*w +: 2] = rr_rd[2*w +: 2] + (srdr_pkg::RRPV_MAX - top_q);
	end

	always_comb begin
		rr_we     = 1'b0;
		dc_we     = 1'b0;
		sg_we     = 1'b0;
		pl_we     = 1'b0;
		ps_we     = 1'b0;
		sk_we     = 1'b0;
		oc_we     = 1'b0;
		row_waddr = set_q;
		dc_waddr  = set_q;
		dc_raddr  = set_q;
		rr_wdata  = rr_rd;
		dc_wdata  = dc_rd;
		sg_wdata  = sg_rd;
		pl_wdata  = line_q;
		ps_wdata  = stride;
		sk_wdata  = streak_nx;
		oc_waddr  = sig_q;
		oc_raddr  = sig_q;
		oc_wdata  = srdr_pkg::sat_inc(o_new_q);
		unique case (state_q)
			ST_CLR: begin
				row_waddr = clr_q[SAW-1:0];
				dc_waddr  = clr_q[SAW-1:0];
				rr_wdata  = '1;
				dc_wdata  = '0;
				sg_wdata  = '0;
				pl_wdata  = '0;
				ps_wdata  = '0;
				sk_wdata  = '0;
				if ({1'b0, clr_q} < (CW+1)'(NUM_SETS)) begin
					rr_we = 1'b1;
					dc_we = 1'b1;
					sg_we = 1'b1;
					pl_we = 1'b1;
					ps_we = 1'b1;
					sk_we = 1'b1;
				end
				oc_waddr = clr_q[SW-1:0];
				oc_wdata = srdr_pkg::OUTCOME_RESET;
				oc_we    = ({1'b0, clr_q} < (CW+1)'(srdr_pkg::SIG_N));
			end
			ST_DEC: begin
				// read row dec_q, write back row dec_q-1 decremented
				dc_raddr = dec_q[SAW-1:0];
				dc_waddr = SAW'(dec_q - DW'(1));
				dc_we    = (dec_q != '0);
				for (int w = 0; w < NUM_WAYS; w++)
					dc_wdata[2*w +: 2] = srdr_pkg::sat_dec(dc_rd[2*w +: 2]);
			end
			ST_VWR: begin
				rr_we    = 1'b1;
				rr_wdata = aged_row;
			end
			ST_U1: begin
				pl_we    = 1'b1;
				ps_we    = 1'b1;
				sk_we    = 1'b1;
				oc_raddr = way_sig;
			end
			ST_U2: begin
				rr_we = 1'b1;
				dc_we = 1'b1;
				oc_we = 1'b1;
				oc_raddr = old_sig_q;
				if (hit_q) begin
					rr_wdata[2*way_q +: 2] = 2'd0;
					dc_wdata[2*way_q +: 2] = srdr_pkg::sat_inc(way_dc);
				end else begin
					sg_we    = 1'b1;
					oc_waddr = old_sig_q;
					oc_wdata = o_old_dec;
					// dead count after its decrement is >= 2 only from 3
					if (stream_q)
						rr_wdata[2*way_q +: 2] = srdr_pkg::RRPV_MAX;
					else if (o_eff >= 2'd2 || way_dc == srdr_pkg::CNT_MAX)
						rr_wdata[2*way_q +: 2] = 2'd0;
					else
						rr_wdata[2*way_q +: 2] = srdr_pkg::RRPV_MAX;
					sg_wdata[SW*way_q +: SW] = sig_q;
					dc_wdata[2*way_q +: 2]   = 2'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			dec_q        <= '0;
			scan_q       <= '0;
			thr_q        <= srdr_pkg::THR_RESET;
			mask_q       <= srdr_pkg::MASK_RESET;
			upd_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					srdr_pkg::REG_STREAK_THR: thr_q  <= cfg_data[3:0];
					srdr_pkg::REG_DECAY_MASK: mask_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR_N - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						req_q  <= req_type;
						hit_q  <= was_hit;
						set_q  <= SAW'(srdr_pkg::mod_sub(16'(set_index), 17'(NUM_SETS)));
						way_q  <= WW'(srdr_pkg::mod_sub(16'(way_index), 17'(NUM_WAYS)));
						line_q <= phys_addr[63:6];
						sig_q  <= pc[5:0] ^ pc[11:6] ^ pc[17:12];
						dec_q  <= '0;
						scan_q <= '0;
						if (req_type && ((upd_cnt_q & mask_q) == 16'd0))
							state_q <= ST_DEC;
						else
							state_q <= ST_RD;
						if (req_type)
							upd_cnt_q <= upd_cnt_q + 16'd1;
					end
				end
				ST_DEC: begin
					dec_q <= dec_q + DW'(1);
					if (dec_q == DW'(NUM_SETS))
						state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= req_q ? ST_U1 : ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_q == '0 || scan_rr > top_q) begin
						top_q    <= scan_rr;
						first_q  <= scan_q;
						dz_v_q   <= (scan_dc == 2'd0);
						dz_idx_q <= scan_q;
					end else if (scan_rr == top_q && !dz_v_q && scan_dc == 2'd0) begin
						dz_v_q   <= 1'b1;
						dz_idx_q <= scan_q;
					end
					scan_q <= scan_q + WW'(1);
					if (scan_q == WW'(NUM_WAYS - 1))
						state_q <= ST_VWR;
				end
				ST_VWR: begin
					victim_q     <= 4'(vidx);
					stream_out_q <= 1'b0;
					out_valid_q  <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_U1: begin
					stream_q  <= streaming;
					o_new_q   <= oc_rd;
					old_sig_q <= way_sig;
					state_q   <= ST_U2;
				end
				ST_U2: begin
					victim_q     <= 4'd0;
					stream_out_q <= !hit_q && stream_q;
					out_valid_q  <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/srdr_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module srdr_ram #(
	parameter int unsigned W  = 8,
	parameter int unsigned D  = 16,
	parameter int unsigned AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
